// ----- sv/ole_pkg.sv -----
// Shared types and constants for the ordered list engine.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ole_pkg;

    // Capacity of the list and the widths that follow from it.
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 8;
    localparam int DATA_W = 32;
    // Width wide enough to compare a position against the count without overflow.
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Command codes.
    localparam logic [2:0] KIND_INS_FRONT = 3'd0;
    localparam logic [2:0] KIND_INS_END   = 3'd1;
    localparam logic [2:0] KIND_INS_POS   = 3'd2;
    localparam logic [2:0] KIND_DEL_FRONT = 3'd3;
    localparam logic [2:0] KIND_DEL_END   = 3'd4;
    localparam logic [2:0] KIND_DEL_POS   = 3'd5;
    localparam logic [2:0] KIND_LIST      = 3'd6;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // One input item.
    typedef struct packed {
        logic [2:0]               kind;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] item;
        logic                     is_last;
        logic [CNT_W-1:0]         entry_count;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic list_emit;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_list;
        logic nonempty;
        logic list_last;
    } sts_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LIST
    } state_t;

endpackage

`default_nettype wire

// ----- sv/ole_ctrl.sv -----
// Controller state machine for the ordered list engine.
// Depends on ole_pkg; drives the datapath through ctl_t and reads sts_t.
`default_nettype none

module ole_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output ole_pkg::ctl_t      ctl,
    input  wire ole_pkg::sts_t sts
);
    import ole_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command outputs.
    always_comb
    begin
        state_next    = state_reg;
        busy          = 1'b1;
        ctl.load      = 1'b0;
        ctl.exec      = 1'b0;
        ctl.list_emit = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // A listing of a non-empty list streams entries; all else finishes here.
                if (sts.is_list && sts.nonempty)
                begin
                    state_next = S_LIST;
                end
                else
                begin
                    ctl.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                ctl.list_emit = 1'b1;
                if (sts.list_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/ole_datapath.sv -----
// Datapath of the ordered list engine: entry register array, fill count,
// index computation, shifting edits and the result register. Depends on ole_pkg.
`default_nettype none

module ole_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ole_pkg::cmd_t    cmd,
    input  wire ole_pkg::ctl_t    ctl,
    output ole_pkg::sts_t         sts,
    output logic                  done,
    output ole_pkg::result_t      result
);
    import ole_pkg::*;

    logic signed [DATA_W-1:0] entries_reg [DEPTH];
    cmd_t                     cmd_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [IDX_W-1:0]         list_idx_reg;
    logic                     done_reg;
    result_t                  result_reg;

    logic [CMP_W-1:0] cnt_w;
    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] pos_m1;
    logic [CMP_W-1:0] idx_w;
    logic [IDX_W-1:0] idx;
    logic [1:0]       status;
    logic             do_ins;
    logic             do_del;
    logic             full;
    logic             empty;

    assign cnt_w  = CMP_W'(count_reg);
    assign pos_w  = CMP_W'(cmd_reg.position);
    assign pos_m1 = pos_w - CMP_W'(1);
    assign full   = (cnt_w >= CMP_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign idx    = idx_w[IDX_W-1:0];

    // Decode the held command into an edit index and a status.
    always_comb
    begin
        status = ST_OK;
        do_ins = 1'b0;
        do_del = 1'b0;
        idx_w  = '0;
        case (cmd_reg.kind)
            KIND_INS_FRONT:
            begin
                do_ins = 1'b1;
            end
            KIND_INS_END:
            begin
                do_ins = 1'b1;
                idx_w  = cnt_w;
            end
            KIND_INS_POS:
            begin
                do_ins = 1'b1;
                if (pos_w == CMP_W'(1) || empty)
                begin
                    idx_w = '0;
                end
                else if (pos_w == '0)
                begin
                    idx_w = CMP_W'(1);
                end
                else if (pos_m1 > cnt_w)
                begin
                    idx_w = cnt_w;
                end
                else
                begin
                    idx_w = pos_m1;
                end
            end
            KIND_DEL_FRONT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    do_del = 1'b1;
                end
            end
            KIND_DEL_END:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    do_del = 1'b1;
                    idx_w  = cnt_w - CMP_W'(1);
                end
            end
            KIND_DEL_POS:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (pos_w == CMP_W'(1))
                begin
                    do_del = 1'b1;
                end
                else if (pos_w == '0 || count_reg == CNT_W'(1))
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    do_del = 1'b1;
                    if (pos_m1 > cnt_w - CMP_W'(1))
                    begin
                        idx_w = cnt_w - CMP_W'(1);
                    end
                    else
                    begin
                        idx_w = pos_m1;
                    end
                end
            end
            KIND_LIST:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
        // An insert into a full list is dropped.
        if (do_ins && full)
        begin
            status = ST_FULL;
            do_ins = 1'b0;
        end
    end

    // Fill count after the edit.
    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Status toward the controller.
    assign sts.is_list   = (cmd_reg.kind == KIND_LIST);
    assign sts.nonempty  = !empty;
    assign sts.list_last = (CNT_W'(list_idx_reg) == count_reg - CNT_W'(1));

    // Command capture and entry array; each entry takes its own value, a neighbor or the new value.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
        end
        if (ctl.exec && do_ins)
        begin
            for (int i = DEPTH - 1; i > 0; i--)
            begin
                if (IDX_W'(i) == idx)
                begin
                    entries_reg[i] <= cmd_reg.value;
                end
                else if (IDX_W'(i) > idx)
                begin
                    entries_reg[i] <= entries_reg[i-1];
                end
            end
            if (idx == '0)
            begin
                entries_reg[0] <= cmd_reg.value;
            end
        end
        else if (ctl.exec && do_del)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                if (IDX_W'(i) >= idx)
                begin
                    entries_reg[i] <= entries_reg[i+1];
                end
            end
        end
    end

    // Fill count, listing index and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            list_idx_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.exec || ctl.list_emit;
            if (ctl.load)
            begin
                list_idx_reg <= '0;
            end
            else if (ctl.list_emit)
            begin
                list_idx_reg <= list_idx_reg + IDX_W'(1);
            end
            if (ctl.exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            result_reg.status      <= status;
            result_reg.item        <= '0;
            result_reg.is_last     <= 1'b1;
            result_reg.entry_count <= count_next;
        end
        else if (ctl.list_emit)
        begin
            result_reg.status      <= ST_OK;
            result_reg.item        <= entries_reg[list_idx_reg];
            result_reg.is_last     <= sts.list_last;
            result_reg.entry_count <= count_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- sv/ordered_list_engine.sv -----
// Edit commands: start loads cmd_reg, the EXEC state applies the edit and done_reg strobes
// the result; a new item is taken only once the engine is back in IDLE and busy is low.
// List command: after the EXEC decode state, N entries stream out one a cycle from S_LIST;
// an empty list gives one ST_EMPTY result instead. The receiver cannot stall the strobe.
// Reset empties the list at once; entry contents are undefined until written.
// Top level of the ordered list engine; depends on ole_pkg, ole_ctrl, ole_datapath.
`default_nettype none

module ordered_list_engine (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire ole_pkg::cmd_t    cmd,
    output logic                  done,
    output ole_pkg::result_t      result
);
    import ole_pkg::*;

    ctl_t ctl;
    sts_t sts;

    // Sequencing.
    ole_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctl   (ctl),
        .sts   (sts)
    );

    // Storage and edits.
    ole_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ctl    (ctl),
        .sts    (sts),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire
